@@ rtl/weighted_point_histogram_assert.svh @@
// Assertion macros for the weighted point histogram RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef WEIGHTED_POINT_HISTOGRAM_ASSERT_SVH
`define WEIGHTED_POINT_HISTOGRAM_ASSERT_SVH
`ifndef SYNTH
`define WPH_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
`define WPH_ASSERT_NXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define WPH_ASSERT_IMP(label, clk, rstn, a, c)
`define WPH_ASSERT_NXT(label, clk, rstn, a, c)
`endif
`endif

@@ rtl/wph_pkg.sv @@
// Shared types and constants for the weighted point histogram.
// No dependencies.
package wph_pkg;
    localparam int MAX_POINTS_DEF = 64;
    localparam int CAP_W = 7;

    typedef enum logic [2:0] {
        KIND_ADD   = 3'd0,
        KIND_PRUNE = 3'd1,
        KIND_LEFT  = 3'd2,
        KIND_VALUE = 3'd3,
        KIND_SCALE = 3'd4
    } kind_t;

    function automatic logic signed [47:0] sat48_add(
        input logic signed [47:0] a, input logic signed [31:0] b);
        logic signed [48:0] s;
        s = {a[47], a} + 49'(b);
        if (s[48] != s[47]) sat48_add = s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        else sat48_add = s[47:0];
    endfunction

    function automatic logic signed [31:0] sat32_of(input logic signed [47:0] x);
        if (x > 48'sd2147483647) sat32_of = 32'h7fffffff;
        else if (x < -48'sd2147483648) sat32_of = 32'h80000000;
        else sat32_of = x[31:0];
    endfunction
endpackage

@@ rtl/wph_table.sv @@
// Sorted point table: value and weight in one memory, registered read.
// Depends on wph_pkg.
module wph_table #(
    parameter int MAX_POINTS = wph_pkg::MAX_POINTS_DEF,
    parameter int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic signed [31:0]   wvalue,
    input  logic signed [31:0]   wweight,
    input  logic [AW-1:0]        raddr,
    output logic signed [31:0]   rvalue,
    output logic signed [31:0]   rweight
);
    import wph_pkg::*;

    logic [63:0] mem [MAX_POINTS];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= {wweight, wvalue};
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rvalue  <= mem[raddr][31:0];
        rweight <= mem[raddr][63:32];
    end
endmodule

@@ rtl/weighted_point_histogram.sv @@
// Weighted point histogram: sorted (value, weight) table with quantile queries.
// The operation walk and the summary walk each read one entry per cycle; scale reads
// an entry, registers its product and then writes it back. One request at a time;
// input is accepted again once the state returns to idle after the result register
// loads, with a pending config write taking priority. Reset: sync active low; fill 0,
// capacity 64.
module weighted_point_histogram #(
    parameter int MAX_POINTS = wph_pkg::MAX_POINTS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [6:0]    cfg_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [71:0]   s_tdata,   // value[31:0], weight[63:32], inclusive[64], zero pad
    input  logic [2:0]    s_tuser,   // kind[2:0]
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [207:0]  m_tdata,   // status, weight_result[48], value_result[32],
                                     // value_none, fill[7], total_mass[48],
                                     // min_value[32], max_value[32], empty_res, zero pad
    output logic          m_tuser    // unused flag, zero
);
    import wph_pkg::*;
    `include "weighted_point_histogram_assert.svh"

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_WALK  = 9'b000000010,  // search / query / prune walk
        ST_SHUP  = 9'b000000100,  // shift right for insert
        ST_SHDN  = 9'b000001000,  // shift left for remove
        ST_SCALE = 9'b000010000,
        ST_SMUL  = 9'b000100000,
        ST_DONE  = 9'b001000000,
        ST_SUM   = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [6:0] cap_reg;
    logic [CW-1:0] cnt_reg, cnt_next, idx_reg, idx_next, stop_reg, stop_next;
    logic [2:0] kind_reg;
    logic signed [31:0] v_reg, w_reg;
    logic incl_reg;
    logic signed [47:0] acc_reg, acc_next, wres_reg, wres_next;
    logic signed [31:0] vres_reg, vres_next, minv_reg, minv_next, maxv_reg, maxv_next;
    logic none_reg, none_next, stat_reg, stat_next, phase_reg, phase_next;
    logic hit_reg, hit_next;
    logic signed [31:0] hold_v_reg;
    logic signed [63:0] prod_reg;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic signed [31:0] wvalue, wweight, rvalue, rweight;

    wph_table #(.MAX_POINTS(MAX_POINTS), .AW(AW)) u_table (
        .aclk(aclk), .we(we), .waddr(waddr), .wvalue(wvalue), .wweight(wweight),
        .raddr(raddr), .rvalue(rvalue), .rweight(rweight)
    );

    logic s_fire, m_load;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign m_tuser   = 1'b0;
    assign s_fire    = s_tvalid && s_tready;
    assign m_load    = (state_reg == ST_OUT) && (!m_tvalid || m_tready);

    // table full: at or above the capacity register or the table depth
    logic add_full;
    assign add_full = (32'(cnt_reg) >= 32'(cap_reg)) || (32'(cnt_reg) >= 32'(MAX_POINTS));

    // floored Q16.16 product, saturated
    logic signed [47:0] prod_sh;
    logic signed [31:0] scaled_w;
    assign prod_sh  = 48'(prod_reg >>> 16);
    assign scaled_w = sat32_of(prod_sh);

    logic signed [47:0] ww_sum;
    logic signed [31:0] ww_sat;
    assign ww_sum = 48'(rweight) + 48'(w_reg);
    assign ww_sat = sat32_of(ww_sum);

    logic signed [47:0] acc_add, wres_add, chk_w, w_ext;
    logic in_table, past_bound;
    assign acc_add    = sat48_add(acc_reg, rweight);
    assign wres_add   = sat48_add(wres_reg, rweight);
    assign chk_w      = incl_reg ? acc_add : acc_reg;
    assign w_ext      = 48'(w_reg);
    assign in_table   = idx_reg < cnt_reg;
    assign past_bound = (rvalue > v_reg) || (incl_reg && rvalue == v_reg);

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg; idx_next = idx_reg; stop_next = stop_reg;
        acc_next = acc_reg; wres_next = wres_reg; vres_next = vres_reg;
        minv_next = minv_reg; maxv_next = maxv_reg; none_next = none_reg;
        stat_next = stat_reg; phase_next = phase_reg; hit_next = hit_reg;
        we = 1'b0; waddr = idx_reg[AW-1:0]; wvalue = v_reg; wweight = w_reg;
        raddr = AW'(idx_reg + 1'b1);
        unique case (state_reg)
            ST_IDLE: begin
                // entry 0 is read so the walk starts with it in hand
                raddr = '0;
                idx_next = '0;
                if (s_fire) begin
                    stop_next = cnt_reg; acc_next = '0; wres_next = '0; vres_next = '0;
                    none_next = (s_tuser == KIND_VALUE); stat_next = 1'b0;
                    phase_next = 1'b0; hit_next = 1'b0;
                    unique case (s_tuser) inside
                        KIND_ADD: begin
                            if (s_tdata[63:32] == 32'd0) state_next = ST_DONE;
                            else if (add_full) begin
                                stat_next = 1'b1; state_next = ST_DONE;
                            end else state_next = ST_WALK;
                        end
                        KIND_PRUNE, KIND_LEFT, KIND_VALUE: state_next = ST_WALK;
                        KIND_SCALE: state_next = ST_SCALE;
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_WALK: begin
                // rvalue/rweight hold entry idx_reg
                idx_next = idx_reg + 1'b1;
                unique case (kind_reg)
                    KIND_ADD: begin
                        if (!in_table || rvalue > v_reg) begin
                            stop_next = idx_reg; idx_next = cnt_reg;
                            phase_next = 1'b0; state_next = ST_SHUP;
                        end else if (rvalue == v_reg) begin
                            if (ww_sat == 32'sd0) begin
                                // entry idx+1 is being read for the shift
                                idx_next = idx_reg; state_next = ST_SHDN;
                            end else begin
                                we = 1'b1; wvalue = rvalue; wweight = ww_sat;
                                state_next = ST_DONE;
                            end
                        end
                    end
                    KIND_PRUNE: begin
                        if (!in_table) begin
                            cnt_next = stop_reg; state_next = ST_DONE;
                        end else if (hit_reg || past_bound) begin
                            wres_next = wres_add;
                            if (!hit_reg) begin
                                hit_next = 1'b1; stop_next = idx_reg;
                            end
                        end
                    end
                    KIND_LEFT: begin
                        if (!in_table) state_next = ST_DONE;
                        else if (rvalue >= v_reg) begin
                            if (incl_reg && rvalue == v_reg) wres_next = wres_add;
                            state_next = ST_DONE;
                        end else wres_next = wres_add;
                    end
                    KIND_VALUE: begin
                        if (!in_table) state_next = ST_DONE;
                        else if (chk_w >= w_ext) begin
                            vres_next = rvalue; none_next = 1'b0; state_next = ST_DONE;
                        end else acc_next = acc_add;
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_SHUP: begin
                // move entry idx-1 to idx, walking down to the insert slot
                if (idx_reg == stop_reg) begin
                    we = 1'b1; waddr = stop_reg[AW-1:0];
                    cnt_next = cnt_reg + 1'b1; phase_next = 1'b0; state_next = ST_DONE;
                end else if (!phase_reg) begin
                    raddr = AW'(idx_reg - 1'b1); phase_next = 1'b1;
                end else begin
                    we = 1'b1; wvalue = rvalue; wweight = rweight;
                    raddr = AW'(idx_reg - 2'd2);
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_SHDN: begin
                // move entry idx+1 to idx
                if (idx_reg + 1'b1 >= cnt_reg) begin
                    cnt_next = cnt_reg - 1'b1; state_next = ST_DONE;
                end else begin
                    we = 1'b1; wvalue = rvalue; wweight = rweight;
                    idx_next = idx_reg + 1'b1; raddr = AW'(idx_reg + 2'd2);
                end
            end
            ST_SCALE: begin
                // product registered this cycle, written back next
                if (!in_table) state_next = ST_DONE;
                else state_next = ST_SMUL;
            end
            ST_SMUL: begin
                we = 1'b1; wvalue = hold_v_reg; wweight = scaled_w;
                idx_next = idx_reg + 1'b1;
                state_next = ST_SCALE;
            end
            ST_DONE: begin
                // start summary walk
                idx_next = '0; raddr = '0; acc_next = '0;
                minv_next = '0; maxv_next = '0;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (!in_table) state_next = ST_OUT;
                else begin
                    if (idx_reg == '0) minv_next = rvalue;
                    maxv_next = rvalue;
                    acc_next = acc_add;
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_OUT: begin
                if (m_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cap_reg <= 7'd64;
            cnt_reg <= '0;
            m_tvalid <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            if (cfg_valid && cfg_ready) cap_reg <= cfg_data;
            if (m_load) m_tvalid <= 1'b1;
            else if (m_tready) m_tvalid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg <= s_tuser; v_reg <= s_tdata[31:0]; w_reg <= s_tdata[63:32];
            incl_reg <= s_tdata[64];
        end
        idx_reg <= idx_next; stop_reg <= stop_next;
        acc_reg <= acc_next; wres_reg <= wres_next; vres_reg <= vres_next;
        none_reg <= none_next; stat_reg <= stat_next; phase_reg <= phase_next;
        hit_reg <= hit_next;
        minv_reg <= minv_next; maxv_reg <= maxv_next;
        if (state_reg == ST_SCALE) begin
            prod_reg <= 64'(rweight) * 64'(w_reg);
            hold_v_reg <= rvalue;
        end
    end

    // result packing
    always_ff @(posedge aclk) begin
        if (m_load) begin
            m_tdata <= {6'd0,
                        cnt_reg == '0,
                        maxv_reg,
                        minv_reg,
                        acc_reg,
                        7'(cnt_reg),
                        none_reg,
                        vres_reg,
                        wres_reg,
                        stat_reg};
        end
    end

    `WPH_ASSERT_IMP(a_fill_cap, aclk, aresetn, 1'b1, cnt_reg <= CW'(MAX_POINTS))
    `WPH_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `WPH_ASSERT_NXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `WPH_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg != ST_IDLE, !s_tready)
endmodule
